FILE: hdl/nvi_pkg.sv
// Shared constants, codes and types of the Neville polynomial interpolator.
`timescale 1ns / 1ps
package nvi_pkg;

  // Table size. Values are signed Q16.16; the update arithmetic is exact
  // integer math, so the fraction width never appears in the logic.
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Divider operand widths: the numerator is the magnitude of a difference
  // of two 33 x 32 bit products, the denominator a difference of abscissae.
  localparam int NUM_W  = 66;
  localparam int DEN_W  = 33;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  localparam logic [30:0] EB_MAX = 31'h7FFF_FFFF;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } nvi_div_stat_t;

endpackage

FILE: hdl/neville_polynomial_interpolator_unit.sv
// Top level of the Neville polynomial interpolator: sequencer, tables, shared multiplier.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_*) carries one request per item: in_tuser is the
// operation (0 add point, 1 evaluate), in_tdata holds coord_x and value_y.
// The result channel (out_*) returns exactly one result per request, in order.
// An add goes straight to its result. An evaluate with n points runs the
// duplicate check over every pair of abscissae, loads the work column and
// then does n(n-1)/2 updates; an update is bound by the shared radix-2
// divider, which works through all 66 numerator bits of every quotient and
// then reports it. The block
// takes one request at a time; in_tready is high only while no request is in
// work. A finished result waits in the output register while the next request
// is taken, and a stalled receiver holds that result until out_tready; the
// sequencer then waits with its next result. Reset empties the table, sets
// the abscissa range to empty (minimum most positive, maximum most negative)
// and drops any pending result. Stored points are not cleared; the point
// count marks them.
module neville_polynomial_interpolator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // coord_x[31:0], value_y[63:32]
  input  logic         in_tuser,   // operation[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // interp_value[31:0], error_bound[62:32],
                                   // x_min[94:63], x_max[126:95],
                                   // point_count[131:127], zero[135:132]
  output logic [2:0]   out_tuser   // status[2:0]
);
  import nvi_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DUP_A = 4'd1;
  localparam logic [3:0] S_DUP_B = 4'd2;
  localparam logic [3:0] S_DUP_C = 4'd3;
  localparam logic [3:0] S_CPY_R = 4'd4;
  localparam logic [3:0] S_CPY_W = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_RD2   = 4'd7;
  localparam logic [3:0] S_RD3   = 4'd8;
  localparam logic [3:0] S_MUL1  = 4'd9;
  localparam logic [3:0] S_MUL2  = 4'd10;
  localparam logic [3:0] S_SUB   = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_WB    = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;

  // Tables.
  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] w_mem [MAX_POINTS];
  logic signed [31:0] x_rd_r, y_rd_r, w_rd_r;
  logic [IDX_W-1:0]   x_addr, w_addr;

  // Block state.
  logic [CNT_W-1:0]   count_r;
  logic signed [31:0] min_r, max_r;

  // Working registers.
  logic signed [31:0] cx_r;
  logic [IDX_W-1:0]   i_r, j_r, k_r;
  logic signed [31:0] xi_r, xj_r, wa_r, wb_r, prev_r;
  logic signed [32:0] a_r, b_r, d_r;
  logic signed [64:0] p1_r, p2_r;
  logic [DEN_W-1:0]   dm_r;
  logic               neg_r, zden_r, ovf_r;

  // Pending result.
  logic signed [31:0] res_val_r;
  logic [30:0]        res_eb_r;
  logic [2:0]         res_st_r;

  // Output register.
  logic               out_valid_r;
  logic [31:0]        o_val_r, o_min_r, o_max_r;
  logic [30:0]        o_eb_r;
  logic [2:0]         o_st_r;
  logic [CNT_W-1:0]   o_cnt_r;

  logic [IDX_W-1:0]   n_m1;
  logic               in_acc, out_load;
  logic signed [31:0] in_x, in_y;

  assign n_m1   = IDX_W'(count_r - 1'b1);
  assign in_x   = in_tdata[31:0];
  assign in_y   = in_tdata[63:32];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Read addresses of the abscissa and work tables.
  always_comb begin
    x_addr = j_r;
    w_addr = j_r;
    unique case (state_r)
      S_DUP_A: x_addr = i_r;
      S_RD1: begin
        x_addr = j_r;
        w_addr = j_r - 1'b1;
      end
      S_RD2: x_addr = j_r - i_r;
      default: begin
        x_addr = j_r;
        w_addr = j_r;
      end
    endcase
  end

  // Registered table reads.
  always_ff @(posedge clk) begin
    x_rd_r <= x_mem[x_addr];
    y_rd_r <= y_mem[k_r];
    w_rd_r <= w_mem[w_addr];
  end

  // Shared multiplier: first product in S_MUL1, second in S_MUL2.
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  assign mul_a = (state_r == S_MUL1) ? a_r : b_r;
  assign mul_b = (state_r == S_MUL1) ? wa_r : wb_r;
  assign mul_p = mul_a * mul_b;

  // Numerator sign and magnitude, denominator magnitude.
  logic signed [65:0] num_diff;
  logic [NUM_W-1:0]   num_mag;
  logic [DEN_W-1:0]   den_mag;
  assign num_diff = {p1_r[64], p1_r} - {p2_r[64], p2_r};
  assign num_mag  = num_diff[65] ? NUM_W'(-num_diff) : NUM_W'(num_diff);
  assign den_mag  = d_r[32] ? DEN_W'(-d_r) : DEN_W'(d_r);

  logic               div_start;
  logic [NUM_W-1:0]   div_quo;
  logic [DEN_W-1:0]   div_rem;
  nvi_div_stat_t      div_stat;
  assign div_start = (state_r == S_SUB) && (den_mag != '0);

  nvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_mag),
    .den   (den_mag),
    .quo   (div_quo),
    .rem   (div_rem),
    .stat  (div_stat)
  );

  // Round to nearest, ties away from zero, then saturate.
  logic               rnd_up;
  logic [NUM_W:0]     quo_rnd;
  logic signed [31:0] q_val;
  logic               q_ovf;
  assign rnd_up  = {div_rem, 1'b0} >= {1'b0, dm_r};
  assign quo_rnd = {1'b0, div_quo} + (NUM_W + 1)'(rnd_up);

  always_comb begin
    q_ovf = 1'b0;
    q_val = '0;
    priority if (zden_r) begin
      q_ovf = 1'b1;
      q_val = '0;
    end else if (neg_r) begin
      if (quo_rnd > (NUM_W + 1)'(33'h0_8000_0000)) begin
        q_ovf = 1'b1;
        q_val = 32'sh8000_0000;
      end else begin
        q_val = -quo_rnd[31:0];
      end
    end else begin
      if (quo_rnd > (NUM_W + 1)'(33'h0_7FFF_FFFF)) begin
        q_ovf = 1'b1;
        q_val = 32'sh7FFF_FFFF;
      end else begin
        q_val = quo_rnd[31:0];
      end
    end
  end

  // Change of the last diagonal element, saturated.
  logic signed [32:0] e_diff;
  logic [32:0]        e_abs;
  logic [30:0]        e_sat;
  assign e_diff = {q_val[31], q_val} - {prev_r[31], prev_r};
  assign e_abs  = e_diff[32] ? 33'(-e_diff) : 33'(e_diff);
  assign e_sat  = (e_abs > {2'b00, EB_MAX}) ? EB_MAX : e_abs[30:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_ADD || count_r == '0) state_nxt = S_DONE;
          else if (count_r == CNT_W'(1))           state_nxt = S_CPY_R;
          else                                     state_nxt = S_DUP_A;
        end
      end
      S_DUP_A: state_nxt = S_DUP_B;
      S_DUP_B: state_nxt = S_DUP_C;
      S_DUP_C: begin
        if (xi_r == x_rd_r) state_nxt = S_DONE;
        else if (j_r != n_m1 ||
                 (IDX_W + 1)'(i_r) + (IDX_W + 1)'(2) <= (IDX_W + 1)'(n_m1))
          state_nxt = S_DUP_A;
        else state_nxt = S_CPY_R;
      end
      S_CPY_R: state_nxt = S_CPY_W;
      S_CPY_W: begin
        if (k_r != n_m1)             state_nxt = S_CPY_R;
        else if (count_r == CNT_W'(1)) state_nxt = S_DONE;
        else                         state_nxt = S_RD1;
      end
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SUB;
      S_SUB:  state_nxt = (den_mag == '0) ? S_WB : S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_WB;
      S_WB: begin
        if (j_r > i_r || i_r != n_m1) state_nxt = S_RD1;
        else                          state_nxt = S_DONE;
      end
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_ADD && count_r != CNT_W'(MAX_POINTS)) begin
      x_mem[count_r[IDX_W-1:0]] <= in_x;
      y_mem[count_r[IDX_W-1:0]] <= in_y;
    end
    if (state_r == S_CPY_W) w_mem[k_r] <= y_rd_r;
    else if (state_r == S_WB) w_mem[j_r] <= q_val;
  end

  // Control state and the table bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= 32'sh7FFF_FFFF;
      max_r       <= 32'sh8000_0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == OP_ADD && count_r != CNT_W'(MAX_POINTS)) begin
        count_r <= count_r + 1'b1;
        if (in_x < min_r) min_r <= in_x;
        if (in_x > max_r) max_r <= in_x;
      end
      out_valid_r <= (out_valid_r && !out_tready) || out_load;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cx_r  <= in_x;
        i_r   <= '0;
        j_r   <= IDX_W'(1);
        k_r   <= '0;
        ovf_r <= 1'b0;
        res_val_r <= '0;
        res_eb_r  <= '0;
        if (in_tuser == OP_ADD)
          res_st_r <= (count_r == CNT_W'(MAX_POINTS)) ? ST_FULL : ST_OK;
        else
          res_st_r <= (count_r == '0) ? ST_EMPTY : ST_OK;
      end
      S_DUP_B: xi_r <= x_rd_r;
      S_DUP_C: begin
        if (xi_r == x_rd_r) begin
          res_st_r <= ST_DUP;
        end else if (j_r != n_m1) begin
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          j_r <= i_r + 2'd2;
        end
      end
      S_CPY_W: begin
        k_r <= k_r + 1'b1;
        if (k_r == n_m1) begin
          prev_r    <= y_rd_r;
          res_val_r <= y_rd_r;
          res_eb_r  <= EB_MAX;
          i_r       <= IDX_W'(1);
          j_r       <= n_m1;
        end
      end
      S_RD2: begin
        xj_r <= x_rd_r;
        wa_r <= w_rd_r;
      end
      S_RD3: begin
        a_r  <= {cx_r[31], cx_r} - {xj_r[31], xj_r};
        b_r  <= {cx_r[31], cx_r} - {x_rd_r[31], x_rd_r};
        d_r  <= {x_rd_r[31], x_rd_r} - {xj_r[31], xj_r};
        wb_r <= w_rd_r;
      end
      S_MUL1: p1_r <= mul_p;
      S_MUL2: p2_r <= mul_p;
      S_SUB: begin
        neg_r  <= num_diff[65] ^ d_r[32];
        dm_r   <= den_mag;
        zden_r <= (den_mag == '0);
      end
      S_WB: begin
        if (q_ovf) ovf_r <= 1'b1;
        if (j_r == n_m1) begin
          prev_r    <= q_val;
          res_val_r <= q_val;
          res_eb_r  <= e_sat;
        end
        if (j_r > i_r) begin
          j_r <= j_r - 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          j_r <= n_m1;
        end
        if (j_r == i_r && i_r == n_m1 && (ovf_r || q_ovf)) res_st_r <= ST_OVF;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_val_r <= res_val_r;
      o_eb_r  <= res_eb_r;
      o_st_r  <= res_st_r;
      o_min_r <= min_r;
      o_max_r <= max_r;
      o_cnt_r <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_st_r;
  assign out_tdata  = {4'b0000, o_cnt_r, o_max_r, o_min_r, o_eb_r, o_val_r};

  // The point count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS)) else $error("point count beyond table size");

  // An empty-table result carries a zero value and a zero error estimate.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_EMPTY) |-> (out_tdata[62:0] == '0))
    else $error("empty-table result not zero");

  // A quotient is written back only after the divider finished it.
  a_wb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && !zden_r) |-> $past(div_stat.done))
    else $error("write-back without a finished division");

endmodule

FILE: hdl/nvi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nvi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nvi_pkg::NUM_W-1:0]   num,
  input  logic [nvi_pkg::DEN_W-1:0]   den,
  output logic [nvi_pkg::NUM_W-1:0]   quo,
  output logic [nvi_pkg::DEN_W-1:0]   rem,
  output nvi_pkg::nvi_div_stat_t      stat
);
  import nvi_pkg::*;

  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W:0]    trial_sub;

  // Shift in the next numerator bit and try to subtract the divisor.
  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // A new request never lands on a division in progress.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

  // The last step raises done in the next cycle.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == DCNT_W'(1)) |=> (done_r && !busy_r))
    else $error("divider did not finish after its last step");

  // The partial remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && den_r != '0) |-> (rem_r < den_r))
    else $error("divider remainder out of range");

endmodule

FILE: verif/neville_polynomial_interpolator_unit_tb.sv
// Self-checking testbench of the Neville polynomial interpolator unit.
`timescale 1ns / 1ps

// Expected result of one request, and the table model that produces it.
typedef struct {
  logic signed [31:0] interp_value;
  logic [30:0]        error_bound;
  logic [2:0]         status;
  logic signed [31:0] x_min;
  logic signed [31:0] x_max;
  logic [4:0]         point_count;
} nvi_result_t;

class nvi_scoreboard;
  logic signed [31:0] tab_x[nvi_pkg::MAX_POINTS];
  logic signed [31:0] tab_y[nvi_pkg::MAX_POINTS];
  int                 npts;
  logic signed [31:0] lo_x;
  logic signed [31:0] hi_x;
  nvi_result_t        pending_results[$];
  int                 errors;
  int                 checked;
  int                 ovf_seen;

  function new();
    npts   = 0;
    lo_x   = 32'sh7FFF_FFFF;
    hi_x   = 32'sh8000_0000;
    errors = 0;
    checked = 0;
    ovf_seen = 0;
  endfunction

  function bit has_x(logic signed [31:0] x);
    for (int i = 0; i < npts; i++) if (tab_x[i] == x) return 1;
    return 0;
  endfunction

  // One Neville update: ((a*qa) - (b*qb)) / d, rounded half away, saturated.
  function logic signed [31:0] quotient(longint a, logic signed [31:0] qa, longint b,
                                         logic signed [31:0] qb, longint d, ref bit ovf);
    logic signed [67:0] sa, sb, sqa, sqb, num;
    logic [67:0]        mag, dm, quo, rem;
    bit                 neg;
    sa = a;
    sb = b;
    sqa = qa;
    sqb = qb;
    num = sa * sqa - sb * sqb;
    mag = (num < 0) ? -num : num;
    dm = (d < 0) ? -d : d;
    neg = (num < 0) != (d < 0);
    quo = mag / dm;
    rem = mag % dm;
    if (rem != 0 && rem >= dm - rem) quo = quo + 1;
    if (neg) begin
      if (quo > 68'h8000_0000) begin
        ovf = 1;
        return 32'sh8000_0000;
      end
      return -quo[31:0];
    end
    if (quo > 68'h7FFF_FFFF) begin
      ovf = 1;
      return 32'sh7FFF_FFFF;
    end
    return quo[31:0];
  endfunction

  // Note an accepted request and queue the result it must produce.
  function void note_request(logic op, logic signed [31:0] cx, logic signed [31:0] vy);
    nvi_result_t        r;
    logic signed [31:0] col[nvi_pkg::MAX_POINTS];
    logic signed [31:0] last;
    longint             diff;
    bit                 dup, ovf;
    r.interp_value = 0;
    r.error_bound = 0;
    r.status = nvi_pkg::ST_OK;
    if (op == nvi_pkg::OP_ADD) begin
      if (npts >= nvi_pkg::MAX_POINTS) begin
        r.status = nvi_pkg::ST_FULL;
      end else begin
        tab_x[npts] = cx;
        tab_y[npts] = vy;
        npts++;
        if (cx < lo_x) lo_x = cx;
        if (cx > hi_x) hi_x = cx;
      end
    end else if (npts == 0) begin
      r.status = nvi_pkg::ST_EMPTY;
    end else begin
      dup = 0;
      ovf = 0;
      for (int i = 0; i < npts; i++)
        for (int j = i + 1; j < npts; j++) if (tab_x[i] == tab_x[j]) dup = 1;
      if (dup) begin
        r.status = nvi_pkg::ST_DUP;
      end else begin
        for (int i = 0; i < npts; i++) col[i] = tab_y[i];
        last = col[npts-1];
        r.error_bound = nvi_pkg::EB_MAX;
        // Each column refines the diagonal in place, from the bottom up.
        for (int i = 1; i < npts; i++) begin
          for (int j = npts - 1; j >= i; j--)
            col[j] = quotient(longint'(cx) - tab_x[j], col[j-1],
                              longint'(cx) - tab_x[j-i], col[j],
                              longint'(tab_x[j-i]) - tab_x[j], ovf);
          diff = longint'(col[npts-1]) - last;
          if (diff < 0) diff = -diff;
          r.error_bound = (diff > 64'h7FFF_FFFF) ? nvi_pkg::EB_MAX : diff[30:0];
          last = col[npts-1];
        end
        r.interp_value = col[npts-1];
        if (ovf) begin
          r.status = nvi_pkg::ST_OVF;
          ovf_seen++;
        end
      end
    end
    r.x_min = lo_x;
    r.x_max = hi_x;
    r.point_count = npts[4:0];
    pending_results = {pending_results, r};
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(nvi_result_t act);
    nvi_result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result value=%h status=%0d", $time, act.interp_value,
               act.status);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    checked++;
    if (act.interp_value !== e.interp_value) begin
      $display("%0t: interp_value expected %h actual %h", $time, e.interp_value,
               act.interp_value);
      errors++;
    end
    if (act.error_bound !== e.error_bound) begin
      $display("%0t: error_bound expected %h actual %h", $time, e.error_bound,
               act.error_bound);
      errors++;
    end
    if (act.status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
      errors++;
    end
    if (act.x_min !== e.x_min) begin
      $display("%0t: x_min expected %h actual %h", $time, e.x_min, act.x_min);
      errors++;
    end
    if (act.x_max !== e.x_max) begin
      $display("%0t: x_max expected %h actual %h", $time, e.x_max, act.x_max);
      errors++;
    end
    if (act.point_count !== e.point_count) begin
      $display("%0t: point_count expected %0d actual %0d", $time, e.point_count,
               act.point_count);
      errors++;
    end
  endfunction
endclass

module neville_polynomial_interpolator_unit_tb;
  import nvi_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;   // coord_x[31:0], value_y[63:32]
  logic         in_tuser;   // operation[0]
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // interp_value, error_bound, x_min, x_max, point_count
  logic [2:0]   out_tuser;  // status[2:0]

  nvi_scoreboard table_model;
  bit            no_idle;
  int            requests_sent;

  neville_polynomial_interpolator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver side: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  // Accepted results are checked on the rising edge.
  always @(posedge clk) begin
    nvi_result_t act;
    if (rst_n && out_tvalid && out_tready) begin
      act.interp_value = out_tdata[31:0];
      act.error_bound = out_tdata[62:32];
      act.x_min = out_tdata[94:63];
      act.x_max = out_tdata[126:95];
      act.point_count = out_tdata[131:127];
      act.status = out_tuser;
      table_model.check_result(act);
    end
  end

  // Drive one request and wait for its handshake.
  task automatic send_request(logic op, logic signed [31:0] cx, logic signed [31:0] vy);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {vy, cx};
    do @(posedge clk); while (!in_tready);
    table_model.note_request(op, cx, vy);
    requests_sent++;
  endtask

  function automatic logic signed [31:0] pick_x();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic logic signed [31:0] pick_y();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  task automatic add_fresh_point();
    logic signed [31:0] x;
    x = pick_x();
    while (table_model.has_x(x)) x = pick_x();
    send_request(OP_ADD, x, pick_y());
  endtask

  // Overall time limit.
  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    table_model = new();
    no_idle = 0;
    requests_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_ADD;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, single point, extreme abscissae and queries.
    send_request(OP_EVAL, 32'sh0, 32'sh7FFF_FFFF);
    send_request(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
    send_request(OP_EVAL, 32'sh0, 32'sh0);
    send_request(OP_EVAL, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
    send_request(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_request(OP_EVAL, 32'sh0, 32'sh0);
    send_request(OP_EVAL, 32'sh8000_0000, 32'sh0);
    send_request(OP_EVAL, 32'sh7FFF_FFFF, 32'sh0);
    send_request(OP_ADD, 32'sh0001_0000, 32'sh0002_0000);
    send_request(OP_EVAL, 32'sh0000_8000, 32'sh0);
    send_request(OP_EVAL, 32'sh0001_0000, 32'sh0);
    send_request(OP_ADD, 32'sh0000_0000, 32'sh0000_0000);
    send_request(OP_EVAL, 32'shFFFF_8000, 32'sh0);

    // Random: grow the table without duplicates, evaluating along the way.
    while (table_model.npts < MAX_POINTS - 1) begin
      no_idle = (requests_sent >= 30 && requests_sent < 50);
      if ($urandom_range(3) == 0) add_fresh_point();
      else send_request(OP_EVAL, pick_x(), $urandom);
    end
    send_request(OP_EVAL, pick_x(), $urandom);
    no_idle = 0;

    // A repeated abscissa fills the table; later adds are dropped.
    send_request(OP_ADD, table_model.tab_x[$urandom_range(MAX_POINTS - 2)], pick_y());
    repeat (55) send_request(1'($urandom_range(1)), $urandom, $urandom);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (table_model.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests, %0d results checked, %0d evaluations overflowed.",
             requests_sent, table_model.checked, table_model.ovf_seen);
    $display("Empty, single point, full table, repeated abscissa and saturation exercised.");
    if (table_model.errors == 0 && table_model.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
